[rtl/core/c3f_pkg.sv]
`default_nettype none

package c3f_pkg;

	localparam int MaxWidth  = 2048;
	localparam int AddrW     = $clog2(MaxWidth);
	localparam int PixW      = 24;
	localparam int ChanW     = 8;
	localparam int WidthRegW = 12;
	localparam int RowW      = 16;
	localparam int ColW      = 11;

	// register indexes, byte address = 4 * index
	localparam logic [1:0] RegWidth  = 2'd0;
	localparam logic [1:0] RegHeight = 2'd1;
	localparam logic [1:0] RegMode   = 2'd2;

	typedef enum logic [2:0] {
		ModeIdentity = 3'd0,
		ModeBlur     = 3'd1,
		ModeSharpen  = 3'd2,
		ModeOutline  = 3'd3,
		ModeEmboss   = 3'd4
	} mode_t;

	// 3x3 neighborhood of one channel, raster order, zero where outside the frame
	typedef logic [8:0][ChanW-1:0] nbhd_t;

endpackage

`default_nettype wire

[rtl/core/conv3x3_image_filter_core.sv]
`default_nettype none

// channel   dir  handshake                        payload
// s_t*      in   s_tvalid / s_tready              s_tdata: blue, green, red
// m_t*      out  m_tvalid / m_tready              m_tdata: blue, green, red, column, row; m_tlast
// apb       in   psel & penable & pwrite, pready  width @0x0, height @0x4, mode @0x8
//
// One pixel per cycle unless stalled; a pixel with n > 1 outputs holds emit until all go out.
// Line store: one 2048 x 48 memory (upper and middle line), read on accept, written as the
// pixel enters the window; a same-column read at that edge is forwarded (width 1).
// Reset clears counters, window, pipeline and config; the line store is not cleared.
// A stalled output register holds the input only while outputs are pending.

module conv3x3_image_filter_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // blue_in[7:0], green_in[15:8], red_in[23:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // blue[7:0], green[15:8], red[23:16], column[34:24],
	                               // row[50:35], zero[55:51]
	output logic        m_tlast,   // frame_done
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import c3f_pkg::*;

	// config
	logic [WidthRegW-1:0] width_q;
	logic [RowW-1:0]      height_q;
	logic [2:0]           mode_q;
	logic                 cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WidthRegW'(MaxWidth);
			height_q <= RowW'(1);
			mode_q   <= ModeIdentity;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				RegWidth:  width_q  <= pwdata[WidthRegW-1:0];
				RegHeight: height_q <= pwdata[RowW-1:0];
				RegMode:   mode_q   <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			RegWidth:  prdata = {{(32-WidthRegW){1'b0}}, width_q};
			RegHeight: prdata = {{(32-RowW){1'b0}}, height_q};
			RegMode:   prdata = {29'b0, mode_q};
			default:   prdata = '0;
		endcase
	end

	// accept stage: counters
	logic [ColW-1:0]      col_q;
	logic [RowW-1:0]      row_q;
	logic [WidthRegW-1:0] w_eff;
	logic [RowW-1:0]      h_eff;
	logic [ColW-1:0]      x_s0;
	logic [RowW-1:0]      y_s0;
	logic                 row_end_s0;
	logic                 last_row_s0;
	logic                 in_fire;

	always_comb begin
		if (width_q == '0) begin
			w_eff = WidthRegW'(1);
		end else if (width_q > WidthRegW'(MaxWidth)) begin
			w_eff = WidthRegW'(MaxWidth);
		end else begin
			w_eff = width_q;
		end
		h_eff = (height_q == '0) ? RowW'(1) : height_q;
		x_s0 = ({1'b0, col_q} >= w_eff) ? ColW'(w_eff - 1'b1) : col_q;
		y_s0 = (row_q >= h_eff) ? h_eff - 1'b1 : row_q;
		row_end_s0  = ({1'b0, x_s0} == w_eff - 1'b1);
		last_row_s0 = (y_s0 == h_eff - 1'b1);
	end

	assign in_fire = s_tvalid & s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_fire) begin
			if (row_end_s0) begin
				col_q <= '0;
				row_q <= last_row_s0 ? '0 : y_s0 + 1'b1;
			end else begin
				col_q <= x_s0 + 1'b1;
				row_q <= y_s0;
			end
		end
	end

	// stage 1: line memory read data arrives
	logic                 s1_valid_q;
	logic [PixW-1:0]      pix_s1;
	logic [ColW-1:0]      x_s1;
	logic [RowW-1:0]      y_s1;
	logic                 row_end_s1;
	logic                 last_row_s1;
	logic                 s1_adv;

	logic [2*PixW-1:0]    line_mem [MaxWidth];
	logic [2*PixW-1:0]    rd_q;
	logic [2*PixW-1:0]    fwd_q;
	logic                 fwd_hit_q;
	logic [2*PixW-1:0]    line_old;
	logic [PixW-1:0]      up_old;
	logic [PixW-1:0]      mid_old;
	logic [2*PixW-1:0]    line_new;

	assign line_old = fwd_hit_q ? fwd_q : rd_q;
	assign up_old   = line_old[2*PixW-1:PixW];
	assign mid_old  = line_old[PixW-1:0];
	assign line_new = {mid_old, pix_s1};

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			line_mem[x_s1[AddrW-1:0]] <= line_new;
		end
		if (in_fire) begin
			rd_q <= line_mem[x_s0[AddrW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			fwd_hit_q  <= 1'b0;
		end else begin
			if (in_fire) begin
				s1_valid_q <= 1'b1;
				fwd_hit_q  <= s1_adv && (x_s1 == x_s0);
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			pix_s1      <= s_tdata;
			x_s1        <= x_s0;
			y_s1        <= y_s0;
			row_end_s1  <= row_end_s0;
			last_row_s1 <= last_row_s0;
			fwd_q       <= line_new;
		end
	end

	// stage 2: window and output emission
	logic [8:0][PixW-1:0] win_q;
	logic [3:0]           pend_s2;
	logic [ColW-1:0]      x_s2;
	logic [RowW-1:0]      y_s2;
	logic [1:0]           sel;
	logic [3:0]           pend_after;
	logic                 out_free;
	logic                 emit_fire;
	logic [3:0]           mask_s1;
	logic [3:0]           row_ok;
	logic [3:0]           col_ok;
	nbhd_t                nb [3];
	logic [ChanW-1:0]     chan_out [3];
	logic [ColW-1:0]      out_col;
	logic [RowW-1:0]      out_row;

	always_comb begin
		if (pend_s2[0]) begin
			sel = 2'd0;
		end else if (pend_s2[1]) begin
			sel = 2'd1;
		end else if (pend_s2[2]) begin
			sel = 2'd2;
		end else begin
			sel = 2'd3;
		end
	end

	assign pend_after = pend_s2 & ~(4'b0001 << sel);
	assign out_free   = ~m_tvalid | m_tready;
	assign emit_fire  = (pend_s2 != '0) && out_free;
	assign s1_adv     = s1_valid_q && (emit_fire ? (pend_after == '0) : (pend_s2 == '0));
	assign s_tready   = ~s1_valid_q | s1_adv;

	assign mask_s1 = {last_row_s1 & row_end_s1,
	                  last_row_s1 & (x_s1 != '0),
	                  (y_s1 != '0) & row_end_s1,
	                  (y_s1 != '0) & (x_s1 != '0)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s2 <= '0;
			win_q   <= '0;
		end else if (s1_adv) begin
			pend_s2 <= mask_s1;
			for (int r = 0; r < 3; r++) begin
				win_q[r*3]   <= win_q[r*3+1];
				win_q[r*3+1] <= win_q[r*3+2];
			end
			win_q[2] <= up_old;
			win_q[5] <= mid_old;
			win_q[8] <= pix_s1;
		end else if (emit_fire) begin
			pend_s2 <= pend_after;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			x_s2 <= x_s1;
			y_s2 <= y_s1;
		end
	end

	// window row r is frame row y-2+r, column c is frame column x-2+c
	assign row_ok = {1'b0, 1'b1, (y_s2 != '0), (y_s2 >= RowW'(2))};
	assign col_ok = {1'b0, 1'b1, (x_s2 != '0), (x_s2 >= ColW'(2))};

	always_comb begin
		logic [1:0] rr;
		logic [1:0] cc;
		logic       use_px;
		logic [3:0] wi;
		for (int ch = 0; ch < 3; ch++) begin
			nb[ch] = '0;
		end
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				rr     = 2'(i) + {1'b0, sel[1]};
				cc     = 2'(j) + {1'b0, sel[0]};
				use_px = row_ok[rr] & col_ok[cc];
				wi     = use_px ? (4'(rr) * 4'd3 + 4'(cc)) : 4'd0;
				for (int ch = 0; ch < 3; ch++) begin
					nb[ch][i*3+j] = use_px ? win_q[wi][ch*ChanW +: ChanW] : '0;
				end
			end
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_chan
		c3f_kernel u_kernel (
			.mode    (mode_t'(mode_q)),
			.nb      (nb[g]),
			.pix_out (chan_out[g])
		);
	end

	assign out_col = sel[0] ? x_s2 : x_s2 - 1'b1;
	assign out_row = sel[1] ? y_s2 : y_s2 - 1'b1;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (emit_fire) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			m_tdata <= {5'b0, out_row, out_col, chan_out[2], chan_out[1], chan_out[0]};
			m_tlast <= (sel == 2'd3);
		end
	end

	// checks
	a_last_at_corner: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |->
			(m_tdata[34:24] == ColW'(w_eff - 1'b1)) && (m_tdata[50:35] == h_eff - 1'b1))
		else $error("frame end flagged away from the last pixel");

	a_no_adv_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && m_tvalid && !m_tready) |-> (pend_s2 == '0))
		else $error("window advanced with outputs still pending");

	a_fwd_same_col: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && s1_adv && (x_s0 == x_s1)) |=> fwd_hit_q)
		else $error("same-column line read missed forwarding");

endmodule

`default_nettype wire

[rtl/core/c3f_kernel.sv]
`default_nettype none

module c3f_kernel (
	input  c3f_pkg::mode_t           mode,
	input  c3f_pkg::nbhd_t           nb,
	output logic [c3f_pkg::ChanW-1:0] pix_out
);
	import c3f_pkg::*;

	logic signed [12:0] p [9];
	logic signed [12:0] acc;

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			p[i] = signed'({5'b0, nb[i]});
		end
		case (mode)
			ModeBlur: begin
				acc = (p[0] >>> 4) + (p[1] >>> 3) + (p[2] >>> 4)
				    + (p[3] >>> 3) + (p[4] >>> 2) + (p[5] >>> 3)
				    + (p[6] >>> 4) + (p[7] >>> 3) + (p[8] >>> 4);
			end
			ModeSharpen: begin
				acc = (p[4] <<< 2) + p[4] - p[1] - p[3] - p[5] - p[7];
			end
			ModeOutline: begin
				acc = (p[4] <<< 3) - p[0] - p[1] - p[2] - p[3]
				    - p[5] - p[6] - p[7] - p[8];
			end
			ModeEmboss: begin
				acc = p[4] + p[5] + p[7] + (p[8] <<< 1)
				    - (p[0] <<< 1) - p[1] - p[3];
			end
			default: begin
				acc = p[4];
			end
		endcase
		if (acc < 0) begin
			pix_out = '0;
		end else if (acc > 13'sd255) begin
			pix_out = '1;
		end else begin
			pix_out = acc[ChanW-1:0];
		end
	end

endmodule

`default_nettype wire
